// ===== rtl/epwt_pkg.sv =====
// Shared types and codes for the executable page window tracker.
package epwt_pkg;

  localparam int PN_W = 20;
  localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;

  typedef enum logic [2:0] {
    KIND_RECORD = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_ADMIT  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ACT_DONE      = 3'd0,
    ACT_CLEAR_NX  = 3'd1,
    ACT_SET_NX    = 3'd2,
    ACT_NOT_FOUND = 3'd3,
    ACT_FULL      = 3'd4,
    ACT_FOUND     = 3'd5
  } action_t;

  typedef struct packed {
    logic            shift;
    logic            wr_en;
    logic [PN_W-1:0] wr_data;
  } cell_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } win_ctl_t;

endpackage

// ===== rtl/epwt_cell.sv =====
// One page list cell: holds a page number, takes its neighbor's on a shift.
module epwt_cell (
  input  logic                               clk,
  input  epwt_pkg::cell_ctl_t                ctl,
  input  logic                               sel,
  input  logic [epwt_pkg::PN_W-1:0]          shift_in,
  output logic [epwt_pkg::PN_W-1:0]          data
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= shift_in;
    end else if (ctl.wr_en && sel) begin
      data <= ctl.wr_data;
    end
  end

endmodule

// ===== rtl/epwt_window.sv =====
// Ring window of admitted pages with head and tail pointers.
module epwt_window #(
  parameter int WINDOW_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  epwt_pkg::win_ctl_t  ctl,
  input  logic [31:0]         wdata,
  output logic                full,
  output logic [31:0]         head_data
);

  localparam int WW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [WW-1:0] LAST = WW'(WINDOW_SLOTS - 1);

  logic [31:0]   mem [WINDOW_SLOTS];
  logic [WW-1:0] head;
  logic [WW-1:0] tail;
  logic [WW-1:0] head_inc;
  logic [WW-1:0] tail_inc;

  assign head_inc = (head == LAST) ? '0 : head + WW'(1);
  assign tail_inc = (tail == LAST) ? '0 : tail + WW'(1);
  assign full     = (tail_inc == head);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    head_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.pop) begin
        head <= head_inc;
      end
      if (ctl.push) begin
        tail <= tail_inc;
      end
    end
  end

endmodule

// ===== rtl/executable_page_window_tracker_top.sv =====
// Top level of the executable page window tracker: control, list cells, window.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  request  | start, busy        | kind, page_address
//  result   | strobe             | action, target_page, entry_index,
//           |                    | pages_listed, last_result
//
// Record, unused kinds, admit without eviction and clear of an empty list give
// their result in the cycle after the request is taken.
// Remove and lookup rotate the list cells once around, then give one result.
// Admit with eviction gives two results back to back; clear all gives one
// result a cycle, one per listed page. Reset empties list and window at once.
// Results cannot be stalled: strobe marks each for exactly one cycle.
module executable_page_window_tracker_top #(
  parameter int LIST_PAGES   = 64,
  parameter int WINDOW_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [31:0] page_address,
  output logic        strobe,
  output logic [2:0]  action,
  output logic [31:0] target_page,
  output logic [5:0]  entry_index,
  output logic [6:0]  pages_listed,
  output logic        last_result
);

  localparam int IW = $clog2(LIST_PAGES);
  localparam int CW = $clog2(LIST_PAGES + 1);
  localparam logic [IW-1:0] STEP_LAST = IW'(LIST_PAGES - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(LIST_PAGES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_FIX    = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_EVICT  = 6'b010000,
    S_ADMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    epwt_pkg::action_t act;
    logic [31:0]       page;
    logic [5:0]        idx;
    logic [6:0]        n;
    logic              last;
  } result_t;

  function automatic result_t make_res(epwt_pkg::action_t a, logic [31:0] page,
                                       logic [5:0] idx, logic [6:0] n, logic last);
    result_t r;
    r.act  = a;
    r.page = page;
    r.idx  = idx;
    r.n    = n;
    r.last = last;
    return r;
  endfunction

  state_t                       state;
  logic [CW-1:0]                count;
  logic [IW-1:0]                step;
  logic                         found;
  logic [IW-1:0]                fidx;
  logic [epwt_pkg::PN_W-1:0]    last_pn;
  logic [31:0]                  addr_q;
  logic                         remove_q;
  result_t                      res;

  epwt_pkg::cell_ctl_t          cell_ctl;
  epwt_pkg::win_ctl_t           win_ctl;
  logic [IW-1:0]                wr_idx;
  logic [epwt_pkg::PN_W-1:0]    cell_data [LIST_PAGES];
  logic [epwt_pkg::PN_W-1:0]    cell0;
  logic                         win_full;
  logic [31:0]                  win_head;
  logic [31:0]                  win_wdata;
  logic                         accept;
  logic [31:0]                  masked;
  logic                         list_full;
  logic                         step_is_last_entry;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign masked    = page_address & epwt_pkg::PAGE_MASK;
  assign list_full = (count == COUNT_MAX);
  assign cell0     = cell_data[0];
  assign step_is_last_entry = ((CW'(step) + CW'(1)) == count);

  always_comb begin
    cell_ctl.shift   = (state == S_SEARCH) || (state == S_DRAIN);
    cell_ctl.wr_en   = (accept && kind == epwt_pkg::KIND_RECORD && !list_full) ||
                       (state == S_FIX && remove_q && found);
    cell_ctl.wr_data = (state == S_FIX) ? last_pn : page_address[31:12];
    wr_idx           = (state == S_FIX) ? fidx : count[IW-1:0];
    win_ctl.push     = (accept && kind == epwt_pkg::KIND_ADMIT && !win_full) ||
                       (state == S_EVICT);
    win_ctl.pop      = (state == S_EVICT);
    win_ctl.clear    = accept && kind == epwt_pkg::KIND_CLEAR;
    win_wdata        = (state == S_EVICT) ? addr_q : page_address;
  end

  for (genvar i = 0; i < LIST_PAGES; i++) begin : g_cell
    epwt_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .sel      (wr_idx == IW'(i)),
      .shift_in (cell_data[(i + 1) % LIST_PAGES]),
      .data     (cell_data[i])
    );
  end

  epwt_window #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .wdata     (win_wdata),
    .full      (win_full),
    .head_data (win_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      step   <= '0;
      found  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q   <= page_address;
            remove_q <= (kind == epwt_pkg::KIND_REMOVE);
            found    <= 1'b0;
            case (kind)
              epwt_pkg::KIND_RECORD: begin
                strobe <= 1'b1;
                if (list_full) begin
                  res <= make_res(epwt_pkg::ACT_FULL, masked, 6'd0, 7'(count), 1'b1);
                end else begin
                  count <= count + CW'(1);
                  res   <= make_res(epwt_pkg::ACT_DONE, masked, 6'(count),
                                    7'(count + CW'(1)), 1'b1);
                end
              end
              epwt_pkg::KIND_REMOVE, epwt_pkg::KIND_LOOKUP: begin
                state <= S_SEARCH;
              end
              epwt_pkg::KIND_ADMIT: begin
                if (win_full) begin
                  state <= S_EVICT;
                end else begin
                  strobe <= 1'b1;
                  res    <= make_res(epwt_pkg::ACT_CLEAR_NX, page_address, 6'd0,
                                     7'(count), 1'b1);
                end
              end
              epwt_pkg::KIND_CLEAR: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  res    <= make_res(epwt_pkg::ACT_DONE, 32'd0, 6'd0, 7'd0, 1'b1);
                end else begin
                  state <= S_DRAIN;
                end
              end
              default: begin
                strobe <= 1'b1;
                res    <= make_res(epwt_pkg::ACT_DONE, 32'd0, 6'd0, 7'(count), 1'b1);
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (!found && (CW'(step) < count) && (cell0 == addr_q[31:12])) begin
            found <= 1'b1;
            fidx  <= step;
          end
          if (step_is_last_entry) begin
            last_pn <= cell0;
          end
          if (step == STEP_LAST) begin
            step  <= '0;
            state <= S_FIX;
          end else begin
            step <= step + IW'(1);
          end
        end
        S_FIX: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
          if (!found) begin
            res <= make_res(epwt_pkg::ACT_NOT_FOUND, addr_q & epwt_pkg::PAGE_MASK,
                            6'd0, 7'(count), 1'b1);
          end else if (remove_q) begin
            count <= count - CW'(1);
            res   <= make_res(epwt_pkg::ACT_DONE, addr_q & epwt_pkg::PAGE_MASK,
                              6'(fidx), 7'(count - CW'(1)), 1'b1);
          end else begin
            res <= make_res(epwt_pkg::ACT_FOUND, addr_q & epwt_pkg::PAGE_MASK,
                            6'(fidx), 7'(count), 1'b1);
          end
        end
        S_DRAIN: begin
          strobe <= 1'b1;
          res    <= make_res(epwt_pkg::ACT_CLEAR_NX, {cell0, 12'd0}, 6'(step), 7'd0,
                             step_is_last_entry);
          if (step_is_last_entry) begin
            step  <= '0;
            count <= '0;
            state <= S_IDLE;
          end else begin
            step <= step + IW'(1);
          end
        end
        S_EVICT: begin
          strobe <= 1'b1;
          res    <= make_res(epwt_pkg::ACT_SET_NX, win_head, 6'd0, 7'(count), 1'b0);
          state  <= S_ADMIT;
        end
        S_ADMIT: begin
          strobe <= 1'b1;
          res    <= make_res(epwt_pkg::ACT_CLEAR_NX, addr_q, 6'd0, 7'(count), 1'b1);
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign action       = res.act;
  assign target_page  = res.page;
  assign entry_index  = res.idx;
  assign pages_listed = res.n;
  assign last_result  = res.last;

  a_single_cycle_kinds: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == epwt_pkg::KIND_RECORD || kind > epwt_pkg::KIND_CLEAR)) |=>
      (strobe && last_result))
    else $error("single-cycle request gave no final result");

  a_results_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_result) |=> strobe)
    else $error("gap inside a multi-result request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("list count past capacity");

  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && action == epwt_pkg::ACT_SET_NX) |-> !last_result)
    else $error("eviction marked as final result");

  a_search_length: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == epwt_pkg::KIND_REMOVE || kind == epwt_pkg::KIND_LOOKUP)) |=>
      (state == S_SEARCH && step == '0))
    else $error("search did not start at the first entry");

endmodule
